### hw/rtl/hgrr_pkg.sv
// shared types and constants of the health gated round robin picker
`default_nettype none
package hgrr_pkg;

	localparam int NUM_BACKENDS_DEF = 16;
	localparam int TICKET_W         = 64;
	localparam int THR_W            = 8;

	localparam logic KIND_REPORT = 1'b0;
	localparam logic KIND_PICK   = 1'b1;

	localparam logic REG_RISE_THRESHOLD = 1'b0;
	localparam logic REG_FALL_THRESHOLD = 1'b1;

	localparam logic [THR_W-1:0] RISE_RESET = 8'd2;
	localparam logic [THR_W-1:0] FALL_RESET = 8'd3;

	typedef struct packed {
		logic       kind;
		logic [3:0] backend_id;
		logic       check_passed;
		logic       exclude_valid;
		logic [3:0] exclude_id;
	} in_word_t;

	typedef struct packed {
		logic        pick_valid;
		logic [3:0]  pick_id;
		logic        health_changed;
		logic        now_healthy;
		logic        first_flip;
		logic [4:0]  healthy_count;
		logic [31:0] pass_total;
		logic [31:0] fail_total;
	} out_word_t;

	typedef struct packed {
		logic [31:0]      pass_tot;
		logic [31:0]      fail_tot;
		logic [THR_W-1:0] pass_str;
		logic [THR_W-1:0] fail_str;
		logic [15:0]      trans;
	} stat_t;

endpackage
`default_nettype wire

### hw/rtl/hgrr_in_if.sv
// request channel: valid, ready and one input word
`default_nettype none
interface hgrr_in_if;
	logic                valid;
	logic                ready;
	hgrr_pkg::in_word_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### hw/rtl/hgrr_out_if.sv
// response channel: valid, ready and one result word
`default_nettype none
interface hgrr_out_if;
	logic                valid;
	logic                ready;
	hgrr_pkg::out_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### hw/rtl/hgrr_ram.sv
// generic single write port ram with registered read
`default_nettype none
module hgrr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output      logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

### hw/rtl/health_gated_round_robin_picker_top.sv
// top level of the health gated round robin picker
// report: EVAL reads statistics, UPD writes them back, FIN posts the result; pick: DIV reduces a
//   ticket mod healthy count, SCAN finds chosen backend (0 to NUM_BACKENDS-1); up to two tickets
// one item in flight; next word accepted the cycle after the result is posted, even while it
//   waits; the result is held back while an earlier result still waits
// arst_n clears thresholds to 2 and 3, all flags, statistics valid bits and the ticket
`default_nettype none
module health_gated_round_robin_picker_top #(
	parameter int NUM_BACKENDS = hgrr_pkg::NUM_BACKENDS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic                      cfg_idx,
	input  wire logic [hgrr_pkg::THR_W-1:0] cfg_data,
	hgrr_in_if.sink                        req,
	hgrr_out_if.source                     rsp
);

	localparam int IW = (NUM_BACKENDS > 1) ? $clog2(NUM_BACKENDS) : 1;
	localparam int CW = $clog2(NUM_BACKENDS + 1);
	localparam int TW = hgrr_pkg::TICKET_W;
	localparam int BW = $clog2(TW);
	localparam int SW = $bits(hgrr_pkg::stat_t);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_UPD,
		ST_DIV,
		ST_SCAN,
		ST_DECIDE,
		ST_FIN
	} state_t;

	state_t                     state_q;
	hgrr_pkg::in_word_t         item_q;
	hgrr_pkg::out_word_t        res_q;
	hgrr_pkg::out_word_t        out_q;
	logic                       out_valid_q;
	logic [hgrr_pkg::THR_W-1:0] rise_q;
	logic [hgrr_pkg::THR_W-1:0] fall_q;
	logic [NUM_BACKENDS-1:0]    healthy_q;
	logic [NUM_BACKENDS-1:0]    ent_valid_q;
	logic [CW-1:0]              hcnt_q;
	logic [TW-1:0]              ticket_q;
	logic [TW-1:0]              tsh_q;
	logic [BW-1:0]              bit_q;
	logic [CW-1:0]              rem_q;
	logic [IW-1:0]              idx_q;
	logic [IW-1:0]              cand_q;
	logic                       second_q;

	logic [IW-1:0]         addr;
	logic                  bid_ok;
	hgrr_pkg::stat_t       rdata;
	hgrr_pkg::stat_t       cur;
	hgrr_pkg::stat_t       nxt;
	hgrr_pkg::out_word_t   eval_res;
	logic                  flag_old;
	logic                  flag_new;
	logic                  chg;
	logic                  first;
	logic [CW-1:0]         hcnt_new;
	logic [CW:0]           rem2;
	logic [CW-1:0]         rem_next;
	logic                  ex_hit;
	logic                  slot_free;

	assign addr      = IW'(item_q.backend_id);
	assign bid_ok    = 32'(item_q.backend_id) < NUM_BACKENDS;
	assign slot_free = !out_valid_q || rsp.ready;
	assign ex_hit    = item_q.exclude_valid && (32'(cand_q) == 32'(item_q.exclude_id));

	hgrr_ram #(
		.WIDTH (SW),
		.DEPTH (NUM_BACKENDS)
	) u_stat_ram (
		.clk   (clk),
		.we    (state_q == ST_UPD),
		.waddr (addr),
		.wdata (nxt),
		.re    (state_q == ST_EVAL),
		.raddr (addr),
		.rdata (rdata)
	);

	// one restoring step of ticket mod healthy count
	always_comb begin
		rem2     = {rem_q, tsh_q[TW-1]};
		rem_next = (rem2 >= {1'b0, hcnt_q}) ? CW'(rem2 - {1'b0, hcnt_q}) : CW'(rem2);
	end

	always_comb begin
		eval_res               = '0;
		eval_res.healthy_count = 5'(hcnt_q);
	end

	// per backend statistics update
	always_comb begin
		cur      = ent_valid_q[addr] ? rdata : '0;
		nxt      = cur;
		flag_old = healthy_q[addr];
		flag_new = flag_old;
		chg      = 1'b0;
		first    = 1'b0;
		if (item_q.check_passed) begin
			if (cur.pass_tot != '1) begin
				nxt.pass_tot = cur.pass_tot + 32'd1;
			end
			nxt.fail_str = '0;
			if (cur.pass_str != '1) begin
				nxt.pass_str = cur.pass_str + 8'd1;
			end
			if (!flag_old && nxt.pass_str >= rise_q) begin
				flag_new = 1'b1;
				chg      = 1'b1;
				first    = (cur.trans == '0);
			end
		end else begin
			if (cur.fail_tot != '1) begin
				nxt.fail_tot = cur.fail_tot + 32'd1;
			end
			nxt.pass_str = '0;
			if (cur.fail_str != '1) begin
				nxt.fail_str = cur.fail_str + 8'd1;
			end
			if (flag_old && nxt.fail_str >= fall_q) begin
				flag_new = 1'b0;
				chg      = 1'b1;
			end
		end
		if (chg && cur.trans != '1) begin
			nxt.trans = cur.trans + 16'd1;
		end
		if (!chg) begin
			hcnt_new = hcnt_q;
		end else if (flag_new) begin
			hcnt_new = hcnt_q + CW'(1);
		end else begin
			hcnt_new = hcnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			item_q      <= '0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
			rise_q      <= hgrr_pkg::RISE_RESET;
			fall_q      <= hgrr_pkg::FALL_RESET;
			healthy_q   <= '0;
			ent_valid_q <= '0;
			hcnt_q      <= '0;
			ticket_q    <= '0;
			tsh_q       <= '0;
			bit_q       <= '0;
			rem_q       <= '0;
			idx_q       <= '0;
			cand_q      <= '0;
			second_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					hgrr_pkg::REG_RISE_THRESHOLD: rise_q <= cfg_data;
					hgrr_pkg::REG_FALL_THRESHOLD: fall_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_FIN && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						item_q  <= req.data;
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					res_q    <= eval_res;
					second_q <= 1'b0;
					if (item_q.kind == hgrr_pkg::KIND_REPORT) begin
						state_q <= bid_ok ? ST_UPD : ST_FIN;
					end else if (hcnt_q == '0) begin
						state_q <= ST_FIN;
					end else begin
						rem_q   <= '0;
						tsh_q   <= ticket_q;
						bit_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_UPD: begin
					ent_valid_q[addr]    <= 1'b1;
					healthy_q[addr]      <= flag_new;
					hcnt_q               <= hcnt_new;
					res_q.health_changed <= chg;
					res_q.now_healthy    <= flag_new;
					res_q.first_flip     <= first;
					res_q.healthy_count  <= 5'(hcnt_new);
					res_q.pass_total     <= nxt.pass_tot;
					res_q.fail_total     <= nxt.fail_tot;
					state_q              <= ST_FIN;
				end
				ST_DIV: begin
					rem_q <= rem_next;
					tsh_q <= {tsh_q[TW-2:0], 1'b0};
					bit_q <= bit_q + BW'(1);
					if (bit_q == BW'(TW - 1)) begin
						ticket_q <= ticket_q + TW'(1);
						idx_q    <= '0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					idx_q <= idx_q + IW'(1);
					if (healthy_q[idx_q]) begin
						if (rem_q == '0) begin
							cand_q  <= idx_q;
							state_q <= ST_DECIDE;
						end else begin
							rem_q <= rem_q - CW'(1);
						end
					end
				end
				ST_DECIDE: begin
					if (!second_q && ex_hit) begin
						if (hcnt_q > CW'(1)) begin
							second_q <= 1'b1;
							rem_q    <= '0;
							tsh_q    <= ticket_q;
							bit_q    <= '0;
							state_q  <= ST_DIV;
						end else begin
							state_q <= ST_FIN;
						end
					end else begin
						res_q.pick_valid <= 1'b1;
						res_q.pick_id    <= 4'(cand_q);
						state_q          <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (slot_free) begin
						out_q   <= res_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	a_hcnt_matches_flags: assert property (@(posedge clk) disable iff (!arst_n)
		32'(hcnt_q) == $countones(healthy_q))
		else $error("healthy count out of step with flags");

	a_pick_is_healthy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && res_q.pick_valid) |-> healthy_q[IW'(res_q.pick_id)])
		else $error("picked backend not healthy");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV || state_q == ST_SCAN) |-> (hcnt_q != '0))
		else $error("ticket reduction with no healthy backend");

endmodule
`default_nettype wire

### tb/health_gated_round_robin_picker_top_test.sv
// testbench for the health gated round robin picker: directed and random words checked against a predictor
`timescale 1ns / 1ps
module health_gated_round_robin_picker_top_test;

	localparam int BACKENDS   = hgrr_pkg::NUM_BACKENDS_DEF;
	localparam int IDLE_LIMIT = 4000;
	localparam int LONG_HOLD  = 400;
	localparam int TAIL       = 20;

	logic                       clk      = 1'b0;
	logic                       arst_n   = 1'b0;
	logic                       cfg_we   = 1'b0;
	logic                       cfg_idx  = hgrr_pkg::REG_RISE_THRESHOLD;
	logic [hgrr_pkg::THR_W-1:0] cfg_data = '0;

	logic               src_valid = 1'b0;
	hgrr_pkg::in_word_t src_word  = '0;
	logic               snk_ready = 1'b0;

	hgrr_in_if  req_ch ();
	hgrr_out_if rsp_ch ();

	assign req_ch.valid = src_valid;
	assign req_ch.data  = src_word;
	assign rsp_ch.ready = snk_ready;

	health_gated_round_robin_picker_top #(.NUM_BACKENDS(BACKENDS)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [hgrr_pkg::THR_W-1:0] rise_thr;
	logic [hgrr_pkg::THR_W-1:0] fall_thr;
	logic             up_flag  [BACKENDS];
	logic [7:0]       pass_run [BACKENDS];
	logic [7:0]       fail_run [BACKENDS];
	logic [31:0]      passes   [BACKENDS];
	logic [31:0]      fails    [BACKENDS];
	logic [15:0]      flips    [BACKENDS];
	logic [63:0]      next_ticket;

	hgrr_pkg::in_word_t  word_backlog [$];
	hgrr_pkg::out_word_t outcome_q [$];

	int send_gap_max   = 0;
	int recv_stall_max = 0;
	int send_wait      = 0;
	int recv_wait      = 0;
	int holds_asked    = 0;
	int holds_done     = 0;
	int mismatch_count = 0;
	int idle_cycles    = 0;

	function automatic int unsigned up_total();
		int unsigned n;
		n = 0;
		for (int i = 0; i < BACKENDS; i++)
			if (up_flag[i])
				n++;
		return n;
	endfunction

	// k-th healthy backend in index order, k = ticket mod healthy count
	function automatic logic [3:0] draw_backend(int unsigned n);
		logic [63:0] k;
		logic [3:0]  hit;
		int unsigned seen;
		k = next_ticket % 64'(n);
		next_ticket = next_ticket + 64'd1;
		hit = '0;
		seen = 0;
		for (int i = 0; i < BACKENDS; i++)
			if (up_flag[i]) begin
				if (64'(seen) == k)
					hit = 4'(i);
				seen++;
			end
		return hit;
	endfunction

	function automatic hgrr_pkg::out_word_t advance_picker(hgrr_pkg::in_word_t w);
		hgrr_pkg::out_word_t r;
		int unsigned         n;
		int                  b;
		logic [3:0]          cand;
		r = '0;
		b = int'(w.backend_id);
		if (w.kind == hgrr_pkg::KIND_REPORT) begin
			if (b < BACKENDS) begin
				if (w.check_passed) begin
					if (passes[b] != '1)
						passes[b] = passes[b] + 32'd1;
					fail_run[b] = '0;
					if (pass_run[b] != '1)
						pass_run[b] = pass_run[b] + 8'd1;
					if (!up_flag[b] && pass_run[b] >= rise_thr) begin
						up_flag[b] = 1'b1;
						r.first_flip = (flips[b] == 16'd0);
						if (flips[b] != '1)
							flips[b] = flips[b] + 16'd1;
						r.health_changed = 1'b1;
					end
				end else begin
					if (fails[b] != '1)
						fails[b] = fails[b] + 32'd1;
					pass_run[b] = '0;
					if (fail_run[b] != '1)
						fail_run[b] = fail_run[b] + 8'd1;
					if (up_flag[b] && fail_run[b] >= fall_thr) begin
						up_flag[b] = 1'b0;
						if (flips[b] != '1)
							flips[b] = flips[b] + 16'd1;
						r.health_changed = 1'b1;
					end
				end
				r.now_healthy = up_flag[b];
				r.pass_total  = passes[b];
				r.fail_total  = fails[b];
			end
		end else begin
			n = up_total();
			if (n != 0) begin
				cand = draw_backend(n);
				if (w.exclude_valid && cand == w.exclude_id) begin
					if (n > 1) begin
						r.pick_valid = 1'b1;
						r.pick_id    = draw_backend(n);
					end
				end else begin
					r.pick_valid = 1'b1;
					r.pick_id    = cand;
				end
			end
		end
		r.healthy_count = 5'(up_total());
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		mismatch_count++;
		$display("%0t: mismatch on %s: got %0h expected %0h", $realtime, what, got, want);
	endtask

	task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin : drive_words
		hgrr_pkg::in_word_t nxt_word;
		logic               nxt_valid;
		int                 gap;
		if (!arst_n) begin
			src_valid <= 1'b0;
			src_word  <= '0;
			send_wait <= 0;
		end else begin
			nxt_valid = src_valid;
			nxt_word  = src_word;
			gap       = send_wait;
			if (src_valid && req_ch.ready) begin
				outcome_q.insert(outcome_q.size(), advance_picker(src_word));
				nxt_valid = 1'b0;
				gap = $urandom_range(0, send_gap_max);
			end
			if (!nxt_valid) begin
				if (gap > 0) begin
					gap--;
				end else if (word_backlog.size() != 0) begin
					nxt_word  = word_backlog.pop_front();
					nxt_valid = 1'b1;
				end
			end
			send_wait <= gap;
			src_valid <= nxt_valid;
			src_word  <= nxt_word;
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin : watch_results
		hgrr_pkg::out_word_t got;
		hgrr_pkg::out_word_t want;
		int                  stall;
		if (!arst_n) begin
			snk_ready <= 1'b0;
			recv_wait <= 0;
		end else begin
			stall = recv_wait;
			if (rsp_ch.valid && snk_ready) begin
				got = rsp_ch.data;
				if (outcome_q.size() == 0) begin
					report_mismatch("word with nothing expected, healthy_count",
						32'(got.healthy_count), 32'd0);
				end else begin
					want = outcome_q.pop_front();
					check_field("pick_valid", 32'(got.pick_valid), 32'(want.pick_valid));
					check_field("pick_id", 32'(got.pick_id), 32'(want.pick_id));
					check_field("health_changed", 32'(got.health_changed),
						32'(want.health_changed));
					check_field("now_healthy", 32'(got.now_healthy), 32'(want.now_healthy));
					check_field("first_flip", 32'(got.first_flip),
						32'(want.first_flip));
					check_field("healthy_count", 32'(got.healthy_count),
						32'(want.healthy_count));
					check_field("pass_total", got.pass_total, want.pass_total);
					check_field("fail_total", got.fail_total, want.fail_total);
				end
				stall = $urandom_range(0, recv_stall_max);
			end
			if (holds_done != holds_asked) begin
				holds_done <= holds_asked;
				stall = LONG_HOLD;
			end
			if (stall > 0) begin
				snk_ready <= 1'b0;
				recv_wait <= stall - 1;
			end else begin
				snk_ready <= 1'b1;
				recv_wait <= 0;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (src_valid && req_ch.ready) || (rsp_ch.valid && snk_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic queue_report(logic [3:0] b, logic ok);
		hgrr_pkg::in_word_t w;
		w.kind          = hgrr_pkg::KIND_REPORT;
		w.backend_id    = b;
		w.check_passed  = ok;
		w.exclude_valid = 1'($urandom_range(0, 1));
		w.exclude_id    = 4'($urandom_range(0, 15));
		word_backlog.insert(word_backlog.size(), w);
	endtask

	task automatic queue_pick(logic ex_on, logic [3:0] ex_id);
		hgrr_pkg::in_word_t w;
		w.kind          = hgrr_pkg::KIND_PICK;
		w.backend_id    = 4'($urandom_range(0, 15));
		w.check_passed  = 1'($urandom_range(0, 1));
		w.exclude_valid = ex_on;
		w.exclude_id    = ex_id;
		word_backlog.insert(word_backlog.size(), w);
	endtask

	// runs of reports on one backend with some noise, mixed with picks
	task automatic queue_traffic(int count);
		int         made;
		int         len;
		int         pick_mix;
		int         run_max;
		logic [3:0] b;
		logic       dir;
		made = 0;
		pick_mix = $urandom_range(25, 60);
		run_max = ((rise_thr > fall_thr) ? int'(rise_thr) : int'(fall_thr)) + 2;
		if (run_max > 12)
			run_max = 12;
		while (made < count) begin
			if ($urandom_range(0, 99) < pick_mix) begin
				queue_pick(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
				made++;
			end else begin
				b   = 4'($urandom_range(0, BACKENDS - 1));
				dir = 1'($urandom_range(0, 1));
				len = $urandom_range(1, run_max);
				repeat (len) begin
					queue_report(b, ($urandom_range(0, 9) == 0) ? !dir : dir);
					made++;
				end
			end
		end
	endtask

	task automatic wait_idle();
		while (word_backlog.size() != 0 || src_valid || outcome_q.size() != 0)
			@(posedge clk);
		repeat (TAIL) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [hgrr_pkg::THR_W-1:0] v);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == hgrr_pkg::REG_RISE_THRESHOLD)
			rise_thr = v;
		else
			fall_thr = v;
	endtask

	task automatic set_thresholds(logic [hgrr_pkg::THR_W-1:0] r,
		logic [hgrr_pkg::THR_W-1:0] f);
		write_reg(hgrr_pkg::REG_RISE_THRESHOLD, r);
		write_reg(hgrr_pkg::REG_FALL_THRESHOLD, f);
		send_gap_max   = ($urandom_range(0, 2) == 0) ? 0 : 10;
		recv_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 10;
	endtask

	initial begin
		logic [3:0] b;
		rise_thr    = hgrr_pkg::RISE_RESET;
		fall_thr    = hgrr_pkg::FALL_RESET;
		next_ticket = '0;
		for (int i = 0; i < BACKENDS; i++) begin
			up_flag[i]  = 1'b0;
			pass_run[i] = '0;
			fail_run[i] = '0;
			passes[i]   = '0;
			fails[i]    = '0;
			flips[i]    = '0;
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(posedge clk);

		// directed, reset thresholds
		queue_pick(1'b1, 4'd15);
		queue_report(4'd0, 1'b1);
		queue_report(4'd0, 1'b1);
		queue_pick(1'b1, 4'd0);
		queue_pick(1'b0, 4'd0);
		queue_report(4'd15, 1'b1);
		queue_report(4'd15, 1'b1);
		repeat (3) queue_pick(1'b1, 4'd15);
		queue_pick(1'b1, 4'd7);
		repeat (3) queue_report(4'd0, 1'b0);
		repeat (2) queue_report(4'd0, 1'b1);
		queue_report(4'd15, 1'b0);
		queue_report(4'd15, 1'b1);
		queue_report(4'd15, 1'b0);
		queue_report(4'd15, 1'b0);
		queue_pick(1'b1, 4'd0);
		wait_idle();

		// every backend healthy
		set_thresholds(8'd1, 8'd1);
		for (int i = 0; i < BACKENDS; i++)
			queue_report(4'(i), 1'b1);
		repeat (10) queue_pick(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
		queue_traffic(150);
		wait_idle();

		// top thresholds, long streak while the receiver holds off
		set_thresholds(8'd255, 8'd255);
		send_gap_max = 0;
		holds_asked++;
		b = 4'($urandom_range(0, BACKENDS - 1));
		repeat (258) queue_report(b, 1'b1);
		repeat (8) queue_pick(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
		repeat (5) queue_report(b, 1'b0);
		queue_traffic(60);
		wait_idle();

		// zero thresholds act as one
		set_thresholds(8'd0, 8'd0);
		queue_traffic(120);
		wait_idle();

		repeat (7) begin
			set_thresholds(8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)));
			if ($urandom_range(0, 3) == 0)
				holds_asked++;
			queue_traffic(150);
			wait_idle();
		end

		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

### filelist.f
hw/rtl/hgrr_pkg.sv
hw/rtl/hgrr_in_if.sv
hw/rtl/hgrr_out_if.sv
hw/rtl/hgrr_ram.sv
hw/rtl/health_gated_round_robin_picker_top.sv
tb/health_gated_round_robin_picker_top_test.sv
